>>> design/spectrum_bar_shaper_core_macros.svh
// ----------------------------------------------------------------------------
// spectrum bar shaper assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAR_SHAPER_CORE_MACROS_SVH
`define SPECTRUM_BAR_SHAPER_CORE_MACROS_SVH

// same-cycle implication
`define SBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg
// types and fixed constants of the spectrum bar shaper
// ----------------------------------------------------------------------------
`default_nettype none

package sbs_pkg;

	// log2 format: 5 integer bits, LOG_BITS fraction bits
	localparam int LOG_BITS = 10;
	localparam int LG_W = 5 + LOG_BITS;
	localparam int W_W = 23;
	localparam int BASE = 15 << LOG_BITS;

	localparam int ONE_Q15 = 32768;
	localparam int SENS = 150;
	localparam int AMP_MIN = 819;
	localparam int AMP_MAX = 40960;

	// register indexes
	localparam logic [2:0] REG_BAR_COUNT = 3'd0;
	localparam logic [2:0] REG_AMP_EXP = 3'd1;
	localparam logic [2:0] REG_SMOOTH = 3'd2;
	localparam logic [2:0] REG_ATTACK = 3'd3;
	localparam logic [2:0] REG_DECAY = 3'd4;

	localparam logic [8:0] RST_BAR_COUNT = 9'd64;
	localparam logic [15:0] RST_AMP_EXP = 16'd8192;
	localparam logic [15:0] RST_SMOOTH = 16'd26214;
	localparam logic [15:0] RST_ATTACK = 16'd16384;
	localparam logic [15:0] RST_DECAY = 16'd31130;

	// log2 by repeated squaring, evaluated at elaboration only
	function automatic logic [LG_W-1:0] lg_const(input logic [31:0] w);
		logic [4:0] msb;
		logic [63:0] m;
		logic [LOG_BITS-1:0] frac;
		msb = '0;
		for (int i = 0; i < W_W; i++) begin
			if (w[i]) msb = 5'(i);
		end
		m = 64'(w) << (30 - int'(msb));
		frac = '0;
		for (int k = 0; k < LOG_BITS; k++) begin
			m = (m * m) >> 30;
			frac = {frac[LOG_BITS-2:0], 1'b0};
			if (m[31]) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return {msb, frac};
	endfunction

	// full-scale log range and its reciprocal for the normalizing divide
	localparam int LMAX = int'(lg_const(32'd4947968)) - BASE;
	localparam int N_W = 28;
	localparam int RECIP_SHIFT = 40;
	localparam longint RECIP = (longint'(1) << RECIP_SHIFT) / LMAX;

	typedef struct packed {
		logic [7:0] idx;
		logic rej;
		logic zero;
		logic [14:0] key;
		logic [14:0] yacc;
	} side_t;

	typedef struct packed {
		logic [7:0] bar_out;
		logic [15:0] shaped_level;
		logic [15:0] peak_level;
		logic [15:0] smooth_level;
		logic rejected;
	} res_t;

endpackage

`default_nettype wire

>>> design/sbs_intf.sv
// ----------------------------------------------------------------------------
// sbs interfaces
// valid/ready channels for bar items, results and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface sbs_in_if;
	logic valid;
	logic ready;
	logic [7:0] bar_index;
	logic [15:0] magnitude;
	modport source (output valid, output bar_index, output magnitude, input ready);
	modport sink (input valid, input bar_index, input magnitude, output ready);
endinterface

interface sbs_out_if;
	logic valid;
	logic ready;
	logic [7:0] bar_out;
	logic [15:0] shaped_level;
	logic [15:0] peak_level;
	logic [15:0] smooth_level;
	logic rejected;
	modport source (output valid, output bar_out, output shaped_level, output peak_level,
		output smooth_level, output rejected, input ready);
	modport sink (input valid, input bar_out, input shaped_level, input peak_level,
		input smooth_level, input rejected, output ready);
endinterface

interface sbs_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/sbs_log2_pipe.sv
// ----------------------------------------------------------------------------
// sbs_log2_pipe
// pipelined fixed-point log2: normalize, then one squaring per stage
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_log2_pipe #(
	parameter int SIDE_W = 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire logic [sbs_pkg::W_W-1:0] in_w,
	input wire logic [SIDE_W-1:0] in_side,
	output logic out_valid,
	output logic [sbs_pkg::LG_W-1:0] out_lg,
	output logic [SIDE_W-1:0] out_side
);

	localparam int F = sbs_pkg::LOG_BITS;

	logic v_s1;
	logic [sbs_pkg::W_W-1:0] w_s1;
	logic [SIDE_W-1:0] side_s1;

	logic v_s [F+1];
	logic [30:0] m_s [F+1];
	logic [F-1:0] frac_s [F+1];
	logic [4:0] msb_s [F+1];
	logic [SIDE_W-1:0] side_s [F+1];

	logic [4:0] msb_c;
	logic [30:0] m_c;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			w_s1 <= in_w;
			side_s1 <= in_side;
		end
	end

	// leading one and mantissa normalization to q1.30
	always_comb begin
		msb_c = '0;
		for (int i = 0; i < sbs_pkg::W_W; i++) begin
			if (w_s1[i]) msb_c = 5'(i);
		end
		m_c = 31'({8'b0, w_s1} << (5'd30 - msb_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_s1;
			m_s[0] <= m_c;
			frac_s[0] <= '0;
			msb_s[0] <= msb_c;
			side_s[0] <= side_s1;
		end
	end

	// one fraction bit per stage
	for (genvar k = 1; k <= F; k++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] t;
		assign sq = 62'(m_s[k-1]) * 62'(m_s[k-1]);
		assign t = sq[61:30];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
				m_s[k] <= t[31] ? t[31:1] : t[30:0];
				frac_s[k] <= {frac_s[k-1][F-2:0], t[31]};
				msb_s[k] <= msb_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[F];
	assign out_lg = {msb_s[F], frac_s[F]};
	assign out_side = side_s[F];

endmodule

`default_nettype wire

>>> design/spectrum_bar_shaper_core.sv
// ----------------------------------------------------------------------------
// spectrum_bar_shaper_core
// per-bar log scaling, amplification, peak hold with decay and smoothing
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------
//  bar_in   | in  | valid / ready | bar_index, magnitude
//  bar_out  | out | valid / ready | bar_out, shaped_level, peak_level,
//           |     |               | smooth_level, rejected
//  cfg      | in  | valid / ready | index, data (ready always high)
//
//  one item per cycle while results are taken; the path runs through 17 log2 pipes
//  of 12 stages each (one for the input, one for the level, 15 for the
//  bit-by-bit inverse search)
//  after reset the bar store is cleared one entry a cycle, every entry in turn,
//  with bar_in.ready low; register writes are taken throughout
//  the whole pipe advances together; a two-entry output buffer lets one more
//  item in while a result waits, then the pipe holds
//
`default_nettype none

`include "spectrum_bar_shaper_core_macros.svh"

module spectrum_bar_shaper_core #(
	parameter int MAX_BARS = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	sbs_cfg_if.sink cfg,
	sbs_in_if.sink bar_in,
	sbs_out_if.source bar_out
);

	localparam int IDX_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
	localparam int CLR_W = $clog2(MAX_BARS + 1);
	localparam int NSTEP = 15;
	localparam int SIDE_W = $bits(sbs_pkg::side_t);
	localparam logic [27:0] RECIP_C = 28'(sbs_pkg::RECIP);
	localparam logic [27:0] LMAX_C = 28'(sbs_pkg::LMAX);
	localparam logic [14:0] BASE_C = 15'(sbs_pkg::BASE);

	// configuration registers
	logic [8:0] bar_count_q;
	logic [15:0] amp_q;
	logic [15:0] smooth_q;
	logic [15:0] attack_q;
	logic [15:0] decay_q;
	logic [15:0] fac_atk_q;
	logic [31:0] fac_prod;

	// flow control
	logic en;
	logic clearing;
	logic accept;
	logic [CLR_W-1:0] clr_q;

	// front end
	logic v_s1;
	logic [sbs_pkg::W_W-1:0] w_s1;
	sbs_pkg::side_t side_s1;
	logic [15:0] vclamp;

	logic lga_v;
	logic [sbs_pkg::LG_W-1:0] lga_lg;
	sbs_pkg::side_t lga_side;

	// divide by the full-scale log range
	logic v_s2, v_s3, v_s4, v_s5;
	logic [27:0] n_s2, n_s3, r_s4;
	logic [15:0] q_s3, q_s4, s_s5;
	sbs_pkg::side_t side_s2, side_s3, side_s4, side_s5;
	logic [14:0] l_c;
	logic [55:0] prod_c;
	logic [16:0] s_c;

	logic lgb_v;
	logic [sbs_pkg::LG_W-1:0] lgb_lg;
	sbs_pkg::side_t lgb_side;

	// exponent
	logic v_s6, v_s7;
	logic [16:0] t_s6;
	sbs_pkg::side_t side_s6, side_s7;
	logic [14:0] d_c;
	logic [31:0] tp_c;

	// inverse search chain
	logic st_v [NSTEP+1];
	sbs_pkg::side_t st_side [NSTEP+1];

	// store stage
	logic v_s8;
	sbs_pkg::side_t side_s8;
	logic [15:0] shaped_s8;
	logic [31:0] rd_s8;
	logic [31:0] mem [MAX_BARS];
	logic mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [31:0] mem_wd;
	logic [IDX_W-1:0] addr_s8;

	logic lw_v_q;
	logic [IDX_W-1:0] lw_addr_q;
	logic [15:0] lw_pk_q, lw_sm_q;

	logic [15:0] old_pk, old_sm, new_pk, fac;
	logic [31:0] dec_c, acc_c;
	logic [16:0] sm_c;
	logic [15:0] new_sm;
	logic push;
	sbs_pkg::res_t res_c;

	// output buffer
	logic out_v_q, skid_v_q;
	sbs_pkg::res_t out_q, skid_q;
	logic take;

	// ---------------- register writes ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_count_q <= sbs_pkg::RST_BAR_COUNT;
			amp_q <= sbs_pkg::RST_AMP_EXP;
			smooth_q <= sbs_pkg::RST_SMOOTH;
			attack_q <= sbs_pkg::RST_ATTACK;
			decay_q <= sbs_pkg::RST_DECAY;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				sbs_pkg::REG_BAR_COUNT: bar_count_q <= cfg.data[8:0];
				sbs_pkg::REG_AMP_EXP: begin
					if (cfg.data < 16'(sbs_pkg::AMP_MIN)) amp_q <= 16'(sbs_pkg::AMP_MIN);
					else if (cfg.data > 16'(sbs_pkg::AMP_MAX)) amp_q <= 16'(sbs_pkg::AMP_MAX);
					else amp_q <= cfg.data;
				end
				sbs_pkg::REG_SMOOTH: smooth_q <= (cfg.data > 16'(sbs_pkg::ONE_Q15)) ?
					16'(sbs_pkg::ONE_Q15) : cfg.data;
				sbs_pkg::REG_ATTACK: attack_q <= (cfg.data > 16'(sbs_pkg::ONE_Q15)) ?
					16'(sbs_pkg::ONE_Q15) : cfg.data;
				sbs_pkg::REG_DECAY: decay_q <= (cfg.data > 16'(sbs_pkg::ONE_Q15)) ?
					16'(sbs_pkg::ONE_Q15) : cfg.data;
				default: ;
			endcase
		end
	end

	// attack-scaled smoothing weight, settles long before an item gets there
	assign fac_prod = 32'(smooth_q) * 32'(attack_q);
	always_ff @(posedge clk) begin
		fac_atk_q <= fac_prod[30:15];
	end

	// ---------------- flow control and store clearing ----------------
	assign en = !skid_v_q;
	assign clearing = (clr_q != CLR_W'(MAX_BARS));
	assign bar_in.ready = en && !clearing;
	assign accept = bar_in.valid && bar_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// ---------------- s1: clamp, reject check, 32768 + 150 v ----------------
	assign vclamp = (bar_in.magnitude > 16'(sbs_pkg::ONE_Q15)) ?
		16'(sbs_pkg::ONE_Q15) : bar_in.magnitude;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			w_s1 <= sbs_pkg::W_W'(sbs_pkg::ONE_Q15) +
				sbs_pkg::W_W'(vclamp) * sbs_pkg::W_W'(sbs_pkg::SENS);
			side_s1.idx <= bar_in.bar_index;
			side_s1.rej <= ({1'b0, bar_in.bar_index} >= bar_count_q) ||
				(32'(bar_in.bar_index) >= MAX_BARS);
			side_s1.zero <= 1'b0;
			side_s1.key <= '0;
			side_s1.yacc <= '0;
		end
	end

	sbs_log2_pipe #(.SIDE_W(SIDE_W)) u_lg_in (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_w(w_s1), .in_side(side_s1),
		.out_valid(lga_v), .out_lg(lga_lg), .out_side(lga_side)
	);

	// ---------------- s2..s5: s = round(L * 32768 / Lmax) ----------------
	assign l_c = lga_lg - BASE_C;
	assign prod_c = 56'(n_s2) * 56'(RECIP_C);
	assign s_c = 17'(q_s4) + ((r_s4 >= LMAX_C) ? 17'd1 : 17'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s2 <= lga_v;
			n_s2 <= {l_c[12:0], 15'b0} + (LMAX_C >> 1);
			side_s2 <= lga_side;
			// estimate is exact or one low
			v_s3 <= v_s2;
			n_s3 <= n_s2;
			q_s3 <= prod_c[55:40];
			side_s3 <= side_s2;
			v_s4 <= v_s3;
			r_s4 <= n_s3 - 28'(q_s3) * LMAX_C;
			q_s4 <= q_s3;
			side_s4 <= side_s3;
			v_s5 <= v_s4;
			s_s5 <= (s_c > 17'(sbs_pkg::ONE_Q15)) ? 16'(sbs_pkg::ONE_Q15) : s_c[15:0];
			side_s5.idx <= side_s4.idx;
			side_s5.rej <= side_s4.rej;
			side_s5.zero <= (s_c == 17'd0);
			side_s5.key <= side_s4.key;
			side_s5.yacc <= side_s4.yacc;
		end
	end

	sbs_log2_pipe #(.SIDE_W(SIDE_W)) u_lg_lvl (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s5), .in_w(sbs_pkg::W_W'(s_s5)), .in_side(side_s5),
		.out_valid(lgb_v), .out_lg(lgb_lg), .out_side(lgb_side)
	);

	// ---------------- s6, s7: target log of the amplified level ----------------
	assign d_c = BASE_C - lgb_lg;
	assign tp_c = 32'(d_c) * 32'(amp_q) + 32'd4096;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= lgb_v;
			t_s6 <= tp_c[29:13];
			side_s6 <= lgb_side;
			v_s7 <= v_s6;
			side_s7.idx <= side_s6.idx;
			side_s7.rej <= side_s6.rej;
			side_s7.zero <= side_s6.zero || (t_s6 > 17'(BASE_C));
			side_s7.key <= BASE_C - t_s6[14:0];
			side_s7.yacc <= '0;
		end
	end

	// ---------------- inverse search, msb first ----------------
	// yacc ends as the largest y with lg(y) below the key; level is yacc + 1
	assign st_v[0] = v_s7;
	assign st_side[0] = side_s7;

	for (genvar j = 0; j < NSTEP; j++) begin : g_srch
		localparam logic [14:0] BIT = 15'(1) << (NSTEP - 1 - j);
		logic o_v;
		logic [sbs_pkg::LG_W-1:0] o_lg;
		sbs_pkg::side_t o_side;
		logic [14:0] cand;

		assign cand = st_side[j].yacc | BIT;

		sbs_log2_pipe #(.SIDE_W(SIDE_W)) u_lg_step (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(st_v[j]), .in_w(sbs_pkg::W_W'(cand)), .in_side(st_side[j]),
			.out_valid(o_v), .out_lg(o_lg), .out_side(o_side)
		);

		always_comb begin
			st_side[j+1] = o_side;
			if (o_lg < o_side.key) st_side[j+1].yacc = o_side.yacc | BIT;
		end
		assign st_v[j+1] = o_v;
	end

	// ---------------- s8: level, bar store read ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= st_v[NSTEP];
			side_s8 <= st_side[NSTEP];
			shaped_s8 <= st_side[NSTEP].zero ? 16'd0 : 16'(st_side[NSTEP].yacc) + 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (en) rd_s8 <= mem[IDX_W'(st_side[NSTEP].idx)];
	end

	// ---------------- update: peak hold and smoothing ----------------
	assign addr_s8 = IDX_W'(side_s8.idx);

	// the bar written last may not yet be in the registered read data; its copy is used instead
	always_comb begin
		if (lw_v_q && (lw_addr_q == addr_s8)) begin
			old_pk = lw_pk_q;
			old_sm = lw_sm_q;
		end else begin
			old_pk = rd_s8[31:16];
			old_sm = rd_s8[15:0];
		end
	end

	assign dec_c = 32'(old_pk) * 32'(decay_q);
	assign new_pk = (shaped_s8 > old_pk) ? shaped_s8 : dec_c[30:15];
	assign fac = (shaped_s8 > old_sm) ? fac_atk_q : smooth_q;
	assign acc_c = 32'(shaped_s8) * (32'(sbs_pkg::ONE_Q15) - 32'(fac)) +
		32'(old_sm) * 32'(fac) + 32'd16384;
	assign sm_c = acc_c[31:15];
	assign new_sm = (sm_c > 17'(sbs_pkg::ONE_Q15)) ? 16'(sbs_pkg::ONE_Q15) : sm_c[15:0];

	assign push = en && v_s8;

	always_comb begin
		res_c.bar_out = side_s8.idx;
		res_c.rejected = side_s8.rej;
		if (side_s8.rej) begin
			res_c.shaped_level = '0;
			res_c.peak_level = '0;
			res_c.smooth_level = '0;
		end else begin
			res_c.shaped_level = shaped_s8;
			res_c.peak_level = new_pk;
			res_c.smooth_level = new_sm;
		end
	end

	// clearing pass owns the write port until it is done
	always_comb begin
		if (clearing) begin
			mem_we = 1'b1;
			mem_wa = clr_q[IDX_W-1:0];
			mem_wd = '0;
		end else begin
			mem_we = push && !side_s8.rej;
			mem_wa = addr_s8;
			mem_wd = {new_pk, new_sm};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_v_q <= 1'b0;
		end else if (push && !side_s8.rej) begin
			lw_v_q <= 1'b1;
			lw_addr_q <= addr_s8;
			lw_pk_q <= new_pk;
			lw_sm_q <= new_sm;
		end
	end

	// ---------------- output register plus skid entry ----------------
	assign take = out_v_q && bar_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_v_q || take) begin
				out_q <= res_c;
				out_v_q <= 1'b1;
			end else begin
				skid_q <= res_c;
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	assign bar_out.valid = out_v_q;
	assign bar_out.bar_out = out_q.bar_out;
	assign bar_out.shaped_level = out_q.shaped_level;
	assign bar_out.peak_level = out_q.peak_level;
	assign bar_out.smooth_level = out_q.smooth_level;
	assign bar_out.rejected = out_q.rejected;

	// ---------------- checks ----------------
	`SBS_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q, "skid entry without output item")
	`SBS_ASSERT_NOW(a_no_accept_clear, clearing, !bar_in.ready, "item taken during store clear")
	`SBS_ASSERT_NOW(a_rej_zero, out_v_q && out_q.rejected, (out_q.shaped_level == 16'd0) && (out_q.peak_level == 16'd0) && (out_q.smooth_level == 16'd0), "rejected item with nonzero levels")
	`SBS_ASSERT_NEXT(a_skid_holds, skid_v_q && !take, skid_v_q, "skid entry lost")

endmodule

`default_nettype wire

>>> verif/spectrum_bar_shaper_core_test.sv
// ----------------------------------------------------------------------------
// spectrum_bar_shaper_core_test
// self-checking bench: random bar items with idle bursts on both channels,
// every result checked against an in-bench model of the log shaping,
// peak hold and smoothing, over several register settings
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_bar_shaper_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	// indexes that map to no register, the write must be dropped
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 260;
	localparam int RANDOM_ITEMS = 1400;

	typedef struct packed {
		logic [7:0] bar;
		logic [15:0] mag;
	} bar_item_t;

	logic clk;
	logic arst_n;

	sbs_cfg_if cfg ();
	sbs_in_if bar_in ();
	sbs_out_if bar_out ();

	spectrum_bar_shaper_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.bar_in(bar_in),
		.bar_out(bar_out)
	);

	// model copy of the registers and the two per-bar stores
	int unsigned m_bar_count;
	int unsigned m_amp_exp;
	int unsigned m_smooth;
	int unsigned m_attack;
	int unsigned m_decay;
	logic [15:0] peak_mem [256];
	logic [15:0] smooth_mem [256];

	bar_item_t pending_items[$];
	sbs_pkg::res_t expected_results[$];

	int n_errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_rejected = 0;
	int idle_count = 0;
	bit quiet = 0;
	bit in_taken = 0;
	int in_gap = 0;
	int out_gap = 0;

	// log2 in Q5.10: msb index plus fraction bits from repeated squaring
	function automatic longint unsigned log2_q(input int unsigned w);
		int unsigned msb;
		longint unsigned m;
		longint unsigned frac;
		msb = 0;
		frac = 0;
		if (w == 0) w = 1;
		while (msb < 31 && (w >> (msb + 1)) != 0) msb++;
		m = longint'(w) << (30 - msb);
		for (int i = 0; i < sbs_pkg::LOG_BITS; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return (longint'(msb) << sbs_pkg::LOG_BITS) | frac;
	endfunction

	// log scaling, then the exponent by inverse search over the log table
	function automatic int unsigned shaped_of(input int unsigned mag);
		longint unsigned base, l, lmax, t;
		int unsigned v, s, lo, hi, mid;
		base = longint'(sbs_pkg::BASE);
		v = (mag > sbs_pkg::ONE_Q15) ? sbs_pkg::ONE_Q15 : mag;
		l = log2_q(sbs_pkg::ONE_Q15 + sbs_pkg::SENS * v) - base;
		lmax = log2_q((sbs_pkg::SENS + 1) * sbs_pkg::ONE_Q15) - base;
		s = int'((l * sbs_pkg::ONE_Q15 + lmax / 2) / lmax);
		if (s > sbs_pkg::ONE_Q15) s = sbs_pkg::ONE_Q15;
		if (s == 0) return 0;
		t = ((base - log2_q(s)) * m_amp_exp + 4096) >> 13;
		if (t > base) return 0;
		lo = 1;
		hi = sbs_pkg::ONE_Q15;
		while (lo < hi) begin
			mid = lo + ((hi - lo) >> 1);
			if (base - log2_q(mid) <= t) hi = mid;
			else lo = mid + 1;
		end
		return lo;
	endfunction

	function automatic int unsigned sat_one(input int unsigned x);
		return (x > sbs_pkg::ONE_Q15) ? sbs_pkg::ONE_Q15 : x;
	endfunction

	// register write as the block stores it: clamps and saturation
	function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			sbs_pkg::REG_BAR_COUNT: m_bar_count = 32'(data[8:0]);
			sbs_pkg::REG_AMP_EXP: begin
				m_amp_exp = (data < sbs_pkg::AMP_MIN) ? sbs_pkg::AMP_MIN :
					((data > sbs_pkg::AMP_MAX) ? sbs_pkg::AMP_MAX : 32'(data));
			end
			sbs_pkg::REG_SMOOTH: m_smooth = sat_one(32'(data));
			sbs_pkg::REG_ATTACK: m_attack = sat_one(32'(data));
			sbs_pkg::REG_DECAY: m_decay = sat_one(32'(data));
			default: ;
		endcase
	endfunction

	// one bar update: expected result, and the stores move on
	function automatic sbs_pkg::res_t bar_update(input bar_item_t it);
		sbs_pkg::res_t r;
		int unsigned shaped, peak, old, fac;
		longint unsigned sm;
		r = '0;
		r.bar_out = it.bar;
		if (it.bar >= m_bar_count) begin
			r.rejected = 1'b1;
			return r;
		end
		shaped = shaped_of(32'(it.mag));
		peak = 32'(peak_mem[it.bar]);
		if (shaped > peak) peak = shaped;
		else peak = 32'((longint'(peak) * m_decay) >> 15);
		peak_mem[it.bar] = peak[15:0];
		old = 32'(smooth_mem[it.bar]);
		fac = m_smooth;
		// rising input: faster attack
		if (shaped > old) fac = 32'((longint'(fac) * m_attack) >> 15);
		sm = (longint'(shaped) * (sbs_pkg::ONE_Q15 - fac) + longint'(old) * fac + 16384) >> 15;
		if (sm > sbs_pkg::ONE_Q15) sm = sbs_pkg::ONE_Q15;
		smooth_mem[it.bar] = sm[15:0];
		r.shaped_level = shaped[15:0];
		r.peak_level = peak[15:0];
		r.smooth_level = sm[15:0];
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// rising edge: take the handshakes, predict and check
	always @(posedge clk) begin
		sbs_pkg::res_t want;
		bit fire;
		bit got_in;
		fire = 0;
		got_in = 0;
		if (arst_n && bar_in.valid && bar_in.ready) begin
			fire = 1;
			got_in = 1;
			expected_results.push_back(bar_update(pending_items.pop_front()));
			n_sent++;
		end
		in_taken <= got_in;
		if (arst_n && bar_out.valid && bar_out.ready) begin
			fire = 1;
			if (expected_results.size() == 0) begin
				$error("result for bar %0d with nothing expected", bar_out.bar_out);
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				n_checked++;
				if (bar_out.rejected) n_rejected++;
				if (bar_out.bar_out !== want.bar_out) begin
					$error("bar_out: expected %0d, got %0d", want.bar_out, bar_out.bar_out);
					n_errors++;
				end
				if (bar_out.shaped_level !== want.shaped_level) begin
					$error("shaped_level: expected %0d, got %0d",
						want.shaped_level, bar_out.shaped_level);
					n_errors++;
				end
				if (bar_out.peak_level !== want.peak_level) begin
					$error("peak_level: expected %0d, got %0d",
						want.peak_level, bar_out.peak_level);
					n_errors++;
				end
				if (bar_out.smooth_level !== want.smooth_level) begin
					$error("smooth_level: expected %0d, got %0d",
						want.smooth_level, bar_out.smooth_level);
					n_errors++;
				end
				if (bar_out.rejected !== want.rejected) begin
					$error("rejected: expected %0d, got %0d", want.rejected, bar_out.rejected);
					n_errors++;
				end
			end
		end
		if (cfg.valid && cfg.ready) fire = 1;
		// watchdog on cycles with no handshake at all
		if (fire || !arst_n) idle_count = 0;
		else idle_count++;
		if (idle_count >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without any item moving", STALL_LIMIT);
			$display("FAIL spectrum_bar_shaper_core");
			$finish;
		end
	end

	// falling edge: item driver with idle bursts, valid held until taken
	always @(negedge clk) begin
		if (bar_in.valid && !in_taken) begin
			// item still waiting, hold it
		end else if (in_gap > 0) begin
			in_gap <= in_gap - 1;
			bar_in.valid <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			in_gap <= $urandom_range(0, 14);
			bar_in.valid <= 1'b0;
		end else if (pending_items.size() > 0) begin
			// the taken item is already popped, front of queue is the next one
			bar_in.valid <= 1'b1;
			bar_in.bar_index <= pending_items[0].bar;
			bar_in.magnitude <= pending_items[0].mag;
		end else begin
			bar_in.valid <= 1'b0;
		end
	end

	// falling edge: result sink with stall bursts
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			bar_out.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_gap <= $urandom_range(0, 14);
			bar_out.ready <= 1'b0;
		end else begin
			bar_out.ready <= 1'b1;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic reg_done();
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic add_item(input int unsigned bar, input int unsigned mag);
		bar_item_t it;
		it.bar = bar[7:0];
		it.mag = mag[15:0];
		pending_items.push_back(it);
	endtask

	function automatic int unsigned rand_mag();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 65535);
			1: return 0;
			2: return $urandom_range(32768, 65535);
			3: return $urandom_range(0, 64);
			default: return $urandom_range(0, 32768);
		endcase
	endfunction

	// bursts on one bar so peaks decay and smoothing settles
	task automatic add_random(input int n);
		int unsigned bar;
		int run;
		run = 0;
		bar = 0;
		for (int i = 0; i < n; i++) begin
			if (run == 0) begin
				run = $urandom_range(1, 6);
				if (m_bar_count > 0 && $urandom_range(0, 9) != 0)
					bar = $urandom_range(0, (m_bar_count > 256 ? 256 : m_bar_count) - 1);
				else
					bar = $urandom_range(0, 255);
			end
			run--;
			add_item(bar, rand_mag());
		end
	endtask

	task automatic random_regs(input bit wild);
		reg_write(sbs_pkg::REG_BAR_COUNT, wild ? 16'($urandom_range(0, 65535)) :
			16'($urandom_range(1, 256)));
		reg_write(sbs_pkg::REG_AMP_EXP, wild ? 16'($urandom_range(0, 65535)) :
			16'($urandom_range(sbs_pkg::AMP_MIN, sbs_pkg::AMP_MAX)));
		reg_write(sbs_pkg::REG_SMOOTH,
			16'($urandom_range(0, wild ? 65535 : sbs_pkg::ONE_Q15)));
		reg_write(sbs_pkg::REG_ATTACK,
			16'($urandom_range(0, wild ? 65535 : sbs_pkg::ONE_Q15)));
		reg_write(sbs_pkg::REG_DECAY,
			16'($urandom_range(0, wild ? 65535 : sbs_pkg::ONE_Q15)));
		reg_done();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = sbs_pkg::REG_BAR_COUNT;
		cfg.data = '0;
		bar_in.valid = 1'b0;
		bar_in.bar_index = '0;
		bar_in.magnitude = '0;
		bar_out.ready = 1'b0;
		m_bar_count = 32'(sbs_pkg::RST_BAR_COUNT);
		m_amp_exp = 32'(sbs_pkg::RST_AMP_EXP);
		m_smooth = 32'(sbs_pkg::RST_SMOOTH);
		m_attack = 32'(sbs_pkg::RST_ATTACK);
		m_decay = 32'(sbs_pkg::RST_DECAY);
		for (int i = 0; i < 256; i++) begin
			peak_mem[i] = '0;
			smooth_mem[i] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset settings: magnitude extremes, oversized values,
		// the first index past the bar count, rise then fall on one bar
		add_item(0, 0);
		add_item(0, 32768);
		add_item(0, 0);
		add_item(0, 0);
		add_item(1, 1);
		add_item(2, 32767);
		add_item(3, 32769);
		add_item(4, 65535);
		add_item(63, 16384);
		add_item(64, 32768);
		add_item(255, 65535);
		add_item(5, 100);
		add_item(5, 30000);
		add_item(5, 200);
		drain();

		// zero bar count rejects everything; spare indexes are ignored
		reg_write(sbs_pkg::REG_BAR_COUNT, 16'd0);
		reg_write(REG_SPARE_LO, 16'hFFFF);
		reg_write(REG_SPARE_HI, 16'h0000);
		reg_done();
		add_item(0, 32768);
		add_item(200, 1000);
		drain();

		// full range, lowest exponent (clamped up), all weights zero
		reg_write(sbs_pkg::REG_BAR_COUNT, 16'd256);
		reg_write(sbs_pkg::REG_AMP_EXP, 16'd0);
		reg_write(sbs_pkg::REG_SMOOTH, 16'd0);
		reg_write(sbs_pkg::REG_ATTACK, 16'd0);
		reg_write(sbs_pkg::REG_DECAY, 16'd0);
		reg_done();
		add_item(255, 32768);
		add_item(255, 10);
		add_item(128, 65535);
		add_random(150);
		drain();

		// top exponent (clamped down), saturated weights, one bar only
		reg_write(sbs_pkg::REG_BAR_COUNT, 16'd1);
		reg_write(sbs_pkg::REG_AMP_EXP, 16'hFFFF);
		reg_write(sbs_pkg::REG_SMOOTH, 16'hFFFF);
		reg_write(sbs_pkg::REG_ATTACK, 16'hFFFF);
		reg_write(sbs_pkg::REG_DECAY, 16'hFFFF);
		reg_done();
		add_item(0, 32768);
		add_item(0, 20000);
		add_item(1, 20000);
		add_random(100);
		drain();

		// exact limits of the exponent, bar count from all ones
		reg_write(sbs_pkg::REG_BAR_COUNT, 16'hFFFF);
		reg_write(sbs_pkg::REG_AMP_EXP, 16'(sbs_pkg::AMP_MIN));
		reg_write(sbs_pkg::REG_SMOOTH, 16'(sbs_pkg::ONE_Q15));
		reg_write(sbs_pkg::REG_ATTACK, 16'(sbs_pkg::ONE_Q15));
		reg_write(sbs_pkg::REG_DECAY, 16'(sbs_pkg::ONE_Q15));
		reg_done();
		add_random(100);
		drain();
		reg_write(sbs_pkg::REG_AMP_EXP, 16'(sbs_pkg::AMP_MAX));
		reg_done();
		add_random(100);
		drain();

		// random settings, some out of range
		for (int ph = 0; ph < 5; ph++) begin
			random_regs(ph % 2 == 1);
			add_random(RANDOM_ITEMS / 7);
			drain();
		end

		// last stretch with no idling on either side
		random_regs(0);
		quiet = 1;
		add_random(RANDOM_ITEMS / 7);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d items through the block, %0d results checked, %0d rejected",
			n_sent, n_checked, n_rejected);
		$display("register extremes, clamped writes and spare indexes covered");
		if (n_errors == 0 && expected_results.size() == 0)
			$display("PASS spectrum_bar_shaper_core");
		else
			$display("FAIL spectrum_bar_shaper_core");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
+incdir+design
design/sbs_pkg.sv
design/sbs_intf.sv
design/sbs_log2_pipe.sv
design/spectrum_bar_shaper_core.sv
verif/spectrum_bar_shaper_core_test.sv
